/* rtl/core/mcr_pkg.sv */
// Shared types and constants for the midpoint circle rasterizer.
// Used by mcr_front, mcr_queue, mcr_back and the top level.
package mcr_pkg;

  localparam int OFF_W   = 13;  // offset magnitude width
  localparam int CTR_W   = 15;  // center coordinate width
  localparam int COORD_W = 16;  // pixel coordinate width
  localparam int DEC_W   = 16;  // decision term width
  localparam int IDX_W   = 3;   // pixel index within a group of eight

  localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // one group of pixels to draw, as handed from front to back
  typedef struct packed {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [OFF_W-1:0]        off_x;
    logic [OFF_W-1:0]        off_y;
    logic                    done;
    logic                    no_point;
  } job_t;

endpackage

/* rtl/core/mcr_front.sv */
// Request front end: holds the circle state, loads it on start, runs one
// midpoint step per step request, and emits a job. Depends on mcr_pkg.
module mcr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic signed [mcr_pkg::CTR_W-1:0] in_center_x,
  input  logic signed [mcr_pkg::CTR_W-1:0] in_center_y,
  input  logic [mcr_pkg::OFF_W-1:0]      in_radius,
  input  logic                           q_ready,
  output logic                           q_push,
  output mcr_pkg::job_t                  q_job
);
  import mcr_pkg::*;

  logic [OFF_W-1:0]        off_x_r, off_x_nxt;
  logic [OFF_W-1:0]        off_y_r, off_y_nxt;
  logic [DEC_W-1:0]        dec_r, dec_nxt;
  logic signed [CTR_W-1:0] cx_r, cx_nxt;
  logic signed [CTR_W-1:0] cy_r, cy_nxt;
  logic                    active_r, active_nxt;

  logic [OFF_W-1:0] x_inc;
  logic [OFF_W-1:0] y_step;
  logic [DEC_W-1:0] dec_step;
  logic [DEC_W-1:0] diff;
  logic             accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept;

  // one midpoint iteration on the held offset
  always_comb begin
    x_inc = off_x_r + OFF_W'(1);
    diff  = '0;
    if (dec_r[DEC_W-1]) begin
      y_step   = off_y_r;
      dec_step = dec_r + DEC_W'({x_inc, 1'b1});
    end else begin
      y_step   = off_y_r - OFF_W'(1);
      diff     = DEC_W'(x_inc) - DEC_W'(y_step);
      dec_step = dec_r + {diff[DEC_W-2:0], 1'b1};
    end
  end

  always_comb begin
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    active_nxt = active_r;
    q_job      = '0;
    priority if (in_req_type == REQ_START) begin
      q_job.cx    = in_center_x;
      q_job.cy    = in_center_y;
      q_job.off_x = '0;
      q_job.off_y = in_radius;
      q_job.done  = (in_radius == '0);
      if (accept) begin
        off_x_nxt  = '0;
        off_y_nxt  = in_radius;
        dec_nxt    = DEC_W'(1) - DEC_W'(in_radius);
        cx_nxt     = in_center_x;
        cy_nxt     = in_center_y;
        active_nxt = !q_job.done;
      end
    end else if (active_r) begin
      q_job.cx    = cx_r;
      q_job.cy    = cy_r;
      q_job.off_x = x_inc;
      q_job.off_y = y_step;
      q_job.done  = (x_inc >= y_step);
      if (accept) begin
        off_x_nxt  = x_inc;
        off_y_nxt  = y_step;
        dec_nxt    = dec_step;
        active_nxt = !q_job.done;
      end
    end else begin
      // step with no circle: one marker result, state untouched
      q_job.no_point = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      active_r <= 1'b0;
    end else begin
      off_x_r  <= off_x_nxt;
      off_y_r  <= off_y_nxt;
      dec_r    <= dec_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

/* rtl/core/mcr_queue.sv */
// Small job FIFO between the front end and the pixel emitter.
// Depends on mcr_pkg for the job type.
module mcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  output logic                          push_ready,
  input  mcr_pkg::job_t                 push_job,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output mcr_pkg::job_t                 pop_job,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import mcr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rptr_r];
  assign count      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH-1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH-1)) ? '0 : rptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/mcr_back.sv */
// Pixel emitter: walks a job's eight symmetric pixels (one for no_point),
// one per unstalled cycle, to a registered output. Depends on mcr_pkg.
module mcr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  mcr_pkg::job_t                     q_job,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mcr_pkg::COORD_W-1:0] out_pixel_x,
  output logic signed [mcr_pkg::COORD_W-1:0] out_pixel_y,
  output logic                              out_last,
  output logic                              out_circle_done,
  output logic                              out_no_point
);
  import mcr_pkg::*;

  logic                      busy_r, busy_nxt;
  job_t                      job_r;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      last_r, done_r, np_r;

  logic                      out_load, grp_end, take;
  logic [COORD_W-1:0]        cx16, cy16, a16, b16;
  logic [COORD_W-1:0]        px, py;
  logic                      is_last;

  assign out_load = busy_r && (!out_valid_r || out_ready);
  assign is_last  = job_r.no_point || (idx_r == LAST_IDX);
  assign grp_end  = out_load && is_last;
  assign q_ready  = !busy_r || grp_end;
  assign take     = q_valid && q_ready;

  // index bit 2 swaps x and y, bit 0 negates the x term, bit 1 the y term
  always_comb begin
    cx16 = COORD_W'(job_r.cx);
    cy16 = COORD_W'(job_r.cy);
    a16  = idx_r[2] ? COORD_W'(job_r.off_y) : COORD_W'(job_r.off_x);
    b16  = idx_r[2] ? COORD_W'(job_r.off_x) : COORD_W'(job_r.off_y);
    px   = idx_r[0] ? (cx16 - a16) : (cx16 + a16);
    py   = idx_r[1] ? (cy16 - b16) : (cy16 + b16);
    if (job_r.no_point) begin
      px = '0;
      py = '0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (out_load) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (grp_end) begin
      busy_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= q_job;
    end
    if (out_load) begin
      px_r   <= px;
      py_r   <= py;
      last_r <= is_last;
      done_r <= job_r.done && !job_r.no_point;
      np_r   <= job_r.no_point;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_last        = last_r;
  assign out_circle_done = done_r;
  assign out_no_point    = np_r;

endmodule

/* rtl/core/midpoint_circle_rasterizer_unit.sv */
// Top level of the midpoint circle rasterizer: front end, job queue and
// pixel emitter. Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
// A start request loads center and radius and yields eight pixels; each
// step request advances the circle one midpoint iteration and yields its
// eight symmetric pixels; a step with no active circle yields one result
// flagged no_point. The emitter puts out one pixel per cycle while out_ready
// holds, so a start or step occupies the output for eight pixels and an idle
// step for one result. The front end updates the circle state on accept and
// parks the pixel group in a QUEUE_DEPTH-entry queue, so it keeps taking
// requests while the output side stalls until that queue fills. A pixel
// passes through the queue, the emitter's job register and its output register.
module midpoint_circle_rasterizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic signed [mcr_pkg::CTR_W-1:0]   in_center_x,
  input  logic signed [mcr_pkg::CTR_W-1:0]   in_center_y,
  input  logic [mcr_pkg::OFF_W-1:0]         in_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mcr_pkg::COORD_W-1:0] out_pixel_x,
  output logic signed [mcr_pkg::COORD_W-1:0] out_pixel_y,
  output logic                              out_last,
  output logic                              out_circle_done,
  output logic                              out_no_point
);
  import mcr_pkg::*;

  job_t                           push_job, pop_job;
  logic                           push_valid, push_ready;
  logic                           pop_valid, pop_ready;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  mcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_ready     (push_ready),
    .q_push      (push_valid),
    .q_job       (push_job)
  );

  mcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .count      (q_count)
  );

  mcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_job           (pop_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_last        (out_last),
    .out_circle_done (out_circle_done),
    .out_no_point    (out_no_point)
  );

  // a group streams without gaps once its first pixel is out
  a_group_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("pixel group interrupted");

  // done flag is uniform across a group
  a_done_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_circle_done == $past(out_circle_done))
    else $error("circle_done changed inside a group");

  // a no_point marker is a lone result with zero coordinates
  a_no_point_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_point |-> out_last && !out_circle_done &&
      out_pixel_x == '0 && out_pixel_y == '0)
    else $error("malformed no_point result");

  // queue never overfills, and input stalls only when it is full
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count <= QUEUE_DEPTH) && (in_ready == (q_count != QUEUE_DEPTH)))
    else $error("job queue occupancy out of range");

endmodule
